[hw/rtl/sac_pkg.sv]
`default_nettype none
package sac_pkg;

  // default geometry: signed Q16.16 coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // face codes of a result word
  localparam int FACE_W = 3;
  localparam logic [FACE_W-1:0] FACE_NONE   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd2;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;

endpackage
`default_nettype wire

[hw/rtl/sac_prep.sv]
`default_nettype none
module sac_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] mover_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] mover_center_y,
  input  wire logic        [COORD_WIDTH-2:0] mover_half_x,
  input  wire logic        [COORD_WIDTH-2:0] mover_half_y,
  input  wire logic signed [COORD_WIDTH-1:0] target_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] target_center_y,
  input  wire logic        [COORD_WIDTH-2:0] target_half_x,
  input  wire logic        [COORD_WIDTH-2:0] target_half_y,
  input  wire logic signed [COORD_WIDTH-1:0] velocity_x,
  input  wire logic signed [COORD_WIDTH-1:0] velocity_y,
  input  wire logic        [COORD_WIDTH-2:0] time_budget,
  output logic                               out_valid,
  output logic [COORD_WIDTH+1:0]             mag_y,
  output logic [COORD_WIDTH+1:0]             mag_x,
  output logic [COORD_WIDTH-1:0]             den_y,
  output logic [COORD_WIDTH-1:0]             den_x,
  output logic [5*COORD_WIDTH+4:0]           side_y,
  output logic [4*COORD_WIDTH+5:0]           side_x
);

  localparam int CW = COORD_WIDTH;
  localparam int GW = CW + 2;
  localparam int NW = CW + 3;
  localparam int MW = CW + 2;

  // stage a: grown box bounds
  logic                 vld_a;
  logic signed [GW-1:0] min_x, max_x, min_y, max_y;
  logic signed [CW-1:0] ox, oy, vx, vy;
  logic [CW-2:0]        budget;

  logic [CW-1:0] ext_x, ext_y;
  assign ext_x = {1'b0, mover_half_x} + {1'b0, target_half_x};
  assign ext_y = {1'b0, mover_half_y} + {1'b0, target_half_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= in_valid;
    end
    if (en) begin
      min_x  <= GW'(target_center_x) - $signed({2'b00, ext_x});
      max_x  <= GW'(target_center_x) + $signed({2'b00, ext_x});
      min_y  <= GW'(target_center_y) - $signed({2'b00, ext_y});
      max_y  <= GW'(target_center_y) + $signed({2'b00, ext_y});
      ox     <= mover_center_x;
      oy     <= mover_center_y;
      vx     <= velocity_x;
      vy     <= velocity_y;
      budget <= time_budget;
    end
  end

  // stage b: distance to the face the ray heads for, as sign and magnitude
  logic                 sel_y, sel_x;
  logic signed [NW-1:0] num_y, num_x;
  logic [NW-1:0]        abs_y, abs_x;
  logic                 try_y, try_x;

  always_comb begin
    sel_y = vy[CW-1];
    sel_x = vx[CW-1];
    num_y = (sel_y ? NW'(max_y) : NW'(min_y)) - NW'(oy);
    num_x = (sel_x ? NW'(max_x) : NW'(min_x)) - NW'(ox);
    abs_y = num_y[NW-1] ? -num_y : num_y;
    abs_x = num_x[NW-1] ? -num_x : num_x;
    try_y = (vy != '0) && (num_y != '0) && (num_y[NW-1] == vy[CW-1]);
    try_x = (vx != '0) && (num_x != '0) && (num_x[NW-1] == vx[CW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_a;
    end
    if (en) begin
      mag_y  <= abs_y[MW-1:0];
      mag_x  <= abs_x[MW-1:0];
      den_y  <= vy[CW-1] ? -vy : vy;
      den_x  <= vx[CW-1] ? -vx : vx;
      side_y <= {budget, try_y, sel_y, ox, vx, min_x, max_x};
      side_x <= {try_x, sel_x, oy, vy, min_y, max_y};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sac_div.sv]
`default_nettype none
module sac_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int SIDE_W      = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [COORD_WIDTH+1:0] in_mag,
  input  wire logic [COORD_WIDTH-1:0] in_den,
  input  wire logic [SIDE_W-1:0]      in_side,
  output logic                        out_valid,
  output logic [COORD_WIDTH-2:0]      out_quot,
  output logic                        out_ovf,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = CW - 1;
  localparam int MW = CW + 2;
  localparam int DW = MW + FRAC_BITS;
  localparam int HW = DW - QW;
  localparam int WW = (HW > CW) ? HW : CW;

  logic [DW-1:0] dividend;
  logic [WW-1:0] hi_ext, den_ext;
  assign dividend = {in_mag, {FRAC_BITS{1'b0}}};
  assign hi_ext   = WW'(dividend[DW-1:QW]);
  assign den_ext  = WW'(in_den);

  logic              vld  [QW+1];
  logic [CW-1:0]     rem  [QW+1];
  logic [QW-1:0]     low  [QW+1];
  logic [QW-1:0]     quot [QW+1];
  logic [CW-1:0]     den  [QW+1];
  logic              ovf  [QW+1];
  logic [SIDE_W-1:0] side [QW+1];

  // entry: quotient overflow check and leading partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      ovf[0]  <= hi_ext >= den_ext;
      rem[0]  <= hi_ext[CW-1:0];
      low[0]  <= dividend[QW-1:0];
      quot[0] <= '0;
      den[0]  <= in_den;
      side[0] <= in_side;
    end
  end

  // one restoring step per stage, msb first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [CW:0] trial;
    logic        qbit;
    assign trial = {rem[k-1], low[k-1][QW-1]};
    assign qbit  = trial >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        rem[k]  <= qbit ? CW'(trial - {1'b0, den[k-1]}) : trial[CW-1:0];
        low[k]  <= low[k-1] << 1;
        quot[k] <= {quot[k-1][QW-2:0], qbit};
        den[k]  <= den[k-1];
        ovf[k]  <= ovf[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quot  = quot[QW];
  assign out_ovf   = ovf[QW];
  assign out_side  = side[QW];

endmodule
`default_nettype wire

[hw/rtl/sac_resolve.sv]
`default_nettype none
module sac_resolve #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [COORD_WIDTH-2:0] quot_y,
  input  wire logic                   ovf_y,
  input  wire logic [5*COORD_WIDTH+4:0] side_y,
  input  wire logic [COORD_WIDTH-2:0] quot_x,
  input  wire logic                   ovf_x,
  input  wire logic [4*COORD_WIDTH+5:0] side_x,
  output logic                        out_valid,
  output logic                        hit_found,
  output logic [COORD_WIDTH-2:0]      hit_when,
  output logic [2:0]                  hit_face
);
  import sac_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int QW = CW - 1;
  localparam int GW = CW + 2;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 1;

  // lane 0 tests the y faces, lane 1 the x faces
  logic [QW-1:0]        budget;
  logic                 l_try [2];
  logic                 l_sel [2];
  logic signed [CW-1:0] l_o   [2];
  logic signed [CW-1:0] l_v   [2];
  logic signed [GW-1:0] l_lo  [2];
  logic signed [GW-1:0] l_hi  [2];
  logic [QW-1:0]        l_q   [2];
  logic                 l_ovf [2];

  assign {budget, l_try[0], l_sel[0], l_o[0], l_v[0], l_lo[0], l_hi[0]} = side_y;
  assign {l_try[1], l_sel[1], l_o[1], l_v[1], l_lo[1], l_hi[1]} = side_x;
  assign l_q[0]   = quot_y;
  assign l_q[1]   = quot_x;
  assign l_ovf[0] = ovf_y;
  assign l_ovf[1] = ovf_x;

  logic                 vld_m, vld_c;
  logic signed [PW-1:0] m_prod [2];
  logic                 m_ok   [2];
  logic                 m_sel  [2];
  logic signed [CW-1:0] m_o    [2];
  logic signed [GW-1:0] m_lo   [2];
  logic signed [GW-1:0] m_hi   [2];
  logic [QW-1:0]        m_t    [2];
  logic                 c_hit  [2];
  logic                 c_sel  [2];
  logic [QW-1:0]        c_t    [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m     <= 1'b0;
      vld_c     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_m     <= in_valid;
      vld_c     <= vld_m;
      out_valid <= vld_c;
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic signed [PW-1:0] shifted;
    logic signed [SW-1:0] coord;
    assign shifted = m_prod[i] >>> FRAC_BITS;
    assign coord   = SW'(m_o[i]) + SW'(shifted);

    always_ff @(posedge clk) begin
      if (en) begin
        // crossing time in range, then travel along the other axis
        m_ok[i]   <= l_try[i] && !l_ovf[i] && (l_q[i] != '0) && (l_q[i] < budget);
        m_prod[i] <= l_v[i] * $signed({1'b0, l_q[i]});
        m_sel[i]  <= l_sel[i];
        m_o[i]    <= l_o[i];
        m_lo[i]   <= l_lo[i];
        m_hi[i]   <= l_hi[i];
        m_t[i]    <= l_q[i];
        // other coordinate inside the grown box, bounds included
        c_hit[i]  <= m_ok[i] && (coord >= SW'(m_lo[i])) && (coord <= SW'(m_hi[i]));
        c_sel[i]  <= m_sel[i];
        c_t[i]    <= m_t[i];
      end
    end
  end

  // earliest hit; y faces keep ties
  logic                 take_x;
  logic [FACE_W-1:0]    face_y, face_x;
  assign take_x = c_hit[1] && (!c_hit[0] || (c_t[1] < c_t[0]));
  assign face_y = c_sel[0] ? FACE_TOP : FACE_BOTTOM;
  assign face_x = c_sel[1] ? FACE_RIGHT : FACE_LEFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (take_x) begin
        hit_found <= 1'b1;
        hit_when  <= c_t[1];
        hit_face  <= face_x;
      end else if (c_hit[0]) begin
        hit_found <= 1'b1;
        hit_when  <= c_t[0];
        hit_face  <= face_y;
      end else begin
        hit_found <= 1'b0;
        hit_when  <= '1;
        hit_face  <= FACE_NONE;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/swept_aabb_collision_core.sv]
// swept box collision core: one pair per word, one word per cycle
// the input word passes the prep stages, the pipelined restoring divider and
// the resolve stages to the output word; the divider makes one quotient bit per stage
// throughput: one word per cycle; the whole pipeline holds while a result waits
// reset: synchronous, clears valid bits only; no other state
`default_nettype none
module swept_aabb_collision_core #(
  parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] mover_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] mover_center_y,
  input  wire logic        [COORD_WIDTH-2:0] mover_half_x,
  input  wire logic        [COORD_WIDTH-2:0] mover_half_y,
  input  wire logic signed [COORD_WIDTH-1:0] target_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] target_center_y,
  input  wire logic        [COORD_WIDTH-2:0] target_half_x,
  input  wire logic        [COORD_WIDTH-2:0] target_half_y,
  input  wire logic signed [COORD_WIDTH-1:0] velocity_x,
  input  wire logic signed [COORD_WIDTH-1:0] velocity_y,
  input  wire logic        [COORD_WIDTH-2:0] time_budget,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit_found,
  output logic [COORD_WIDTH-2:0]             hit_when,
  output logic [sac_pkg::FACE_W-1:0]         hit_face
);
  import sac_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int YSW = 5 * CW + 5;
  localparam int XSW = 4 * CW + 6;

  // global advance: move when the output register is free or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic           p_valid;
  logic [CW+1:0]  p_mag_y, p_mag_x;
  logic [CW-1:0]  p_den_y, p_den_x;
  logic [YSW-1:0] p_side_y, d_side_y;
  logic [XSW-1:0] p_side_x, d_side_x;
  logic           d_valid_y, d_valid_x;
  logic [CW-2:0]  d_quot_y, d_quot_x;
  logic           d_ovf_y, d_ovf_x;

  sac_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk, .rst, .en, .in_valid,
    .mover_center_x, .mover_center_y, .mover_half_x, .mover_half_y,
    .target_center_x, .target_center_y, .target_half_x, .target_half_y,
    .velocity_x, .velocity_y, .time_budget,
    .out_valid(p_valid), .mag_y(p_mag_y), .mag_x(p_mag_x),
    .den_y(p_den_y), .den_x(p_den_x), .side_y(p_side_y), .side_x(p_side_x)
  );

  // crossing time for the y faces
  sac_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .SIDE_W(YSW)) u_div_y (
    .clk, .rst, .en, .in_valid(p_valid), .in_mag(p_mag_y), .in_den(p_den_y),
    .in_side(p_side_y), .out_valid(d_valid_y), .out_quot(d_quot_y),
    .out_ovf(d_ovf_y), .out_side(d_side_y)
  );

  // crossing time for the x faces
  sac_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .SIDE_W(XSW)) u_div_x (
    .clk, .rst, .en, .in_valid(p_valid), .in_mag(p_mag_x), .in_den(p_den_x),
    .in_side(p_side_x), .out_valid(d_valid_x), .out_quot(d_quot_x),
    .out_ovf(d_ovf_x), .out_side(d_side_x)
  );

  sac_resolve #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk, .rst, .en, .in_valid(d_valid_y),
    .quot_y(d_quot_y), .ovf_y(d_ovf_y), .side_y(d_side_y),
    .quot_x(d_quot_x), .ovf_x(d_ovf_x), .side_x(d_side_x),
    .out_valid, .hit_found, .hit_when, .hit_face
  );

`ifndef NO_ASSERTIONS
  // both divider lanes step in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    d_valid_y == d_valid_x)
    else $error("divider lanes out of step");

  // flag and face code agree
  a_face_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_found == (hit_face != FACE_NONE)))
    else $error("hit flag and face disagree");

  // miss reports all-ones time, hit reports a positive time
  a_when_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> (hit_when == '1))
    else $error("miss without all-ones time");

  a_when_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_found |-> (hit_when != '0))
    else $error("hit at time zero");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word right after reset");
`endif

endmodule
`default_nettype wire
